### src/nrcm_pkg.sv
// Shared types and constants for the row/column-major reorder block.
// No dependencies; every other file of the block imports this package.
package nrcm_pkg;

	localparam int LANES     = 4;   // dimensions handled by the index datapath
	localparam int DATA_W    = 64;
	localparam int IDX_W     = 48;
	localparam int OFS_W     = 52;
	localparam int SIZE_W    = 5;
	localparam int EXT_REG_W = 13;
	localparam int NDIM_W    = 3;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = EXT_REG_W;
	localparam int MAX_ELEM_BYTES = 16;

	localparam logic [NDIM_W-1:0]    RST_NUM_DIMS   = 3'd2;
	localparam logic [EXT_REG_W-1:0] RST_EXTENT     = 13'd1;
	localparam logic [SIZE_W-1:0]    RST_ELEM_BYTES = 5'd8;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_NUM_DIMS      = 3'd0,
		REG_EXTENT_0      = 3'd1,
		REG_EXTENT_1      = 3'd2,
		REG_EXTENT_2      = 3'd3,
		REG_EXTENT_3      = 3'd4,
		REG_DIRECTION     = 3'd5,
		REG_ELEMENT_BYTES = 3'd6,
		REG_COMPLEX_SPLIT = 3'd7
	} cfg_reg_e;

	// Decoded configuration shared by the front and back parts.
	typedef struct packed {
		logic [NDIM_W-1:0] num_dims;
		logic              dims_ok;
		logic              direction;
		logic [SIZE_W-1:0] src_bytes;
		logic [SIZE_W-1:0] dst_bytes;
	} nrcm_ctrl_t;

	typedef struct packed {
		logic full;
		logic empty;
	} nrcm_qstat_t;

endpackage

### src/nrcm_in_if.sv
// Input channel of the reorder block: one element per item.
// Depends on nrcm_pkg for the data width.
interface nrcm_in_if import nrcm_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] data_low;
	logic [DATA_W-1:0] data_high;

	modport source (output valid, data_low, data_high, input ready);
	modport sink   (input valid, data_low, data_high, output ready);
endinterface

### src/nrcm_out_if.sv
// Output channel of the reorder block: indices, byte offsets and data per item.
// Depends on nrcm_pkg for the field widths.
interface nrcm_out_if import nrcm_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [IDX_W-1:0]  src_index;
	logic [IDX_W-1:0]  dest_index;
	logic [OFS_W-1:0]  src_byte_offset;
	logic [OFS_W-1:0]  dest_byte_offset;
	logic [DATA_W-1:0] out_low;
	logic [DATA_W-1:0] out_high;
	logic              array_done;
	logic              dims_error;

	modport source (output valid, src_index, dest_index, src_byte_offset, dest_byte_offset,
		out_low, out_high, array_done, dims_error, input ready);
	modport sink   (input valid, src_index, dest_index, src_byte_offset, dest_byte_offset,
		out_low, out_high, array_done, dims_error, output ready);
endinterface

### src/nrcm_queue.sv
// Small flop-based FIFO that decouples the front part from the back part.
// Depends on nrcm_pkg for the status struct.
module nrcm_queue import nrcm_pkg::*; #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output nrcm_qstat_t      stat
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [NW-1:0]    count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + NW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - NW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	assign rdata      = mem_q[rd_ptr_q];
	assign stat.full  = (count_q == NW'(DEPTH));
	assign stat.empty = (count_q == '0);

endmodule

### src/nrcm_front.sv
// Front part: accepts elements, flags a bad dimension count and walks the
// position counters in source order. Depends on nrcm_pkg and nrcm_in_if.
module nrcm_front import nrcm_pkg::*; #(
	parameter int CW       = 12,
	parameter int EW       = 13,
	parameter int MAX_DIMS = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	nrcm_in_if.sink                    din,
	input  logic                       clear,
	input  logic [LANES-1:0][EW-1:0]   ext,
	input  nrcm_ctrl_t                 ctrl,
	input  logic                       q_full,
	output logic                       push,
	output logic [LANES-1:0][CW-1:0]   cnt,
	output logic                       done,
	output logic                       err,
	output logic [DATA_W-1:0]          data_low,
	output logic [DATA_W-1:0]          data_high
);

	logic [MAX_DIMS-1:0][CW-1:0] cnt_q;
	logic [MAX_DIMS-1:0][CW-1:0] cnt_nxt;
	logic                        wrap;

	assign din.ready = !q_full;
	assign push      = din.valid && din.ready;

	// Step the fastest dimension of the source order; a carry ripples to the
	// next one and all used counters wrap after the last element.
	always_comb begin
		int   d;
		logic carry;
		cnt_nxt = cnt_q;
		carry   = 1'b1;
		for (int k = 0; k < MAX_DIMS; k++) begin
			d = ctrl.direction ? k : MAX_DIMS - 1 - k;
			if (carry && (NDIM_W'(d) < ctrl.num_dims)) begin
				if (EW'(cnt_q[d]) + EW'(1) >= ext[d]) begin
					cnt_nxt[d] = '0;
				end else begin
					cnt_nxt[d] = cnt_q[d] + CW'(1);
					carry      = 1'b0;
				end
			end
		end
		wrap = carry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (clear) begin
			cnt_q <= '0;
		end else if (push && ctrl.dims_ok) begin
			cnt_q <= cnt_nxt;
		end
	end

	for (genvar g = 0; g < LANES; g++) begin : g_lane
		if (g < MAX_DIMS) begin : g_used
			assign cnt[g] = cnt_q[g];
		end else begin : g_unused
			assign cnt[g] = '0;
		end
	end

	assign done      = wrap && ctrl.dims_ok;
	assign err       = !ctrl.dims_ok;
	assign data_low  = din.data_low;
	assign data_high = din.data_high;

endmodule

### src/nrcm_back.sv
// Back part: four-stage pipeline that forms row and column indices by
// multiply-add over the extents, then the byte offsets. Depends on nrcm_pkg
// and nrcm_out_if.
module nrcm_back import nrcm_pkg::*; #(
	parameter int CW = 12,
	parameter int EW = 13
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     q_valid,
	input  logic [LANES-1:0][CW-1:0] q_cnt,
	input  logic                     q_done,
	input  logic                     q_err,
	input  logic [DATA_W-1:0]        q_low,
	input  logic [DATA_W-1:0]        q_high,
	output logic                     q_pop,
	input  logic [LANES-1:0][EW-1:0] ext,
	input  nrcm_ctrl_t               ctrl,
	nrcm_out_if.source               dout
);

	localparam int P1 = CW + EW;
	localparam int P2 = P1 + EW;
	localparam int P3 = (P2 + EW > IDX_W) ? P2 + EW : IDX_W;
	localparam int PO = IDX_W + SIZE_W;

	logic en;

	logic                     v_s1, v_s2, v_s3, v_s4;
	logic [P1-1:0]            row_s1, col_s1;
	logic [P2-1:0]            row_s2, col_s2;
	logic [IDX_W-1:0]         src_s3, dst_s3;
	logic [LANES-1:0][CW-1:0] c_s1, c_s2;
	logic                     done_s1, done_s2, done_s3;
	logic                     err_s1, err_s2, err_s3;
	logic [DATA_W-1:0]        low_s1, low_s2, low_s3, high_s1, high_s2, high_s3;

	logic [IDX_W-1:0]  src_idx_s4, dst_idx_s4;
	logic [OFS_W-1:0]  src_ofs_s4, dst_ofs_s4;
	logic [DATA_W-1:0] low_s4, high_s4;
	logic              done_s4, err_s4;

	logic [P3-1:0] row3, col3;
	logic [PO-1:0] src_ofs, dst_ofs;

	// The whole pipeline holds while the output register waits.
	assign en    = !v_s4 || dout.ready;
	assign q_pop = en && q_valid;

	assign row3    = P3'(row_s2) * P3'(ext[3]) + P3'(c_s2[3]);
	assign col3    = P3'(col_s2) * P3'(ext[0]) + P3'(c_s2[0]);
	assign src_ofs = PO'(src_s3) * PO'(ctrl.src_bytes);
	assign dst_ofs = PO'(dst_s3) * PO'(ctrl.dst_bytes);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= q_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			row_s1  <= P1'(q_cnt[0]) * P1'(ext[1]) + P1'(q_cnt[1]);
			col_s1  <= P1'(q_cnt[3]) * P1'(ext[2]) + P1'(q_cnt[2]);
			c_s1    <= q_cnt;
			done_s1 <= q_done;
			err_s1  <= q_err;
			low_s1  <= q_low;
			high_s1 <= q_high;

			row_s2  <= P2'(row_s1) * P2'(ext[2]) + P2'(c_s1[2]);
			col_s2  <= P2'(col_s1) * P2'(ext[1]) + P2'(c_s1[1]);
			c_s2    <= c_s1;
			done_s2 <= done_s1;
			err_s2  <= err_s1;
			low_s2  <= low_s1;
			high_s2 <= high_s1;

			src_s3  <= ctrl.direction ? col3[IDX_W-1:0] : row3[IDX_W-1:0];
			dst_s3  <= ctrl.direction ? row3[IDX_W-1:0] : col3[IDX_W-1:0];
			done_s3 <= done_s2;
			err_s3  <= err_s2;
			low_s3  <= low_s2;
			high_s3 <= high_s2;

			// An item with a bad dimension count leaves with its indices, offsets, data and done flag zero.
			src_idx_s4 <= err_s3 ? '0 : src_s3;
			dst_idx_s4 <= err_s3 ? '0 : dst_s3;
			src_ofs_s4 <= err_s3 ? '0 : src_ofs[OFS_W-1:0];
			dst_ofs_s4 <= err_s3 ? '0 : dst_ofs[OFS_W-1:0];
			low_s4     <= err_s3 ? '0 : low_s3;
			high_s4    <= err_s3 ? '0 : high_s3;
			done_s4    <= done_s3 && !err_s3;
			err_s4     <= err_s3;
		end
	end

	assign dout.valid            = v_s4;
	assign dout.src_index        = src_idx_s4;
	assign dout.dest_index       = dst_idx_s4;
	assign dout.src_byte_offset  = src_ofs_s4;
	assign dout.dest_byte_offset = dst_ofs_s4;
	assign dout.out_low          = low_s4;
	assign dout.out_high         = high_s4;
	assign dout.array_done       = done_s4;
	assign dout.dims_error       = err_s4;

endmodule

### src/nrcm_row_col_major_reorder_top.sv
// Throughput: one item per cycle while the output is ready; the index
// multiply-add pipeline in the back part and a two-entry queue set that
// figure, and a waiting result holds the pipeline while the queue keeps
// taking items until it is full. Accepted items pass the queue, then s1 to s4.
// Reset: configuration returns to its defaults, position counters to zero,
// queue and pipeline empty. Any configuration write restarts the array.
module nd_row_col_major_reorder_top import nrcm_pkg::*; #(
	parameter int MAX_EXTENT = 4096,
	parameter int MAX_DIMS   = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	nrcm_in_if.sink              din,
	nrcm_out_if.source           dout,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam int CW      = $clog2(MAX_EXTENT);
	localparam int EW      = $clog2(MAX_EXTENT + 1);
	localparam int Q_W     = LANES * CW + 2 + 2 * DATA_W;
	localparam int Q_DEPTH = 2;

	logic [NDIM_W-1:0]                num_dims_q;
	logic [LANES-1:0][EXT_REG_W-1:0]  extent_q;
	logic                             direction_q;
	logic [SIZE_W-1:0]                elem_bytes_q;
	logic                             split_q;

	logic [LANES-1:0][EW-1:0] ext;
	nrcm_ctrl_t               ctrl;
	logic [SIZE_W-1:0]        full_bytes;
	logic [SIZE_W-1:0]        half_bytes;

	logic                     push, pop;
	logic [LANES-1:0][CW-1:0] f_cnt, b_cnt;
	logic                     f_done, f_err, b_done, b_err;
	logic [DATA_W-1:0]        f_low, f_high, b_low, b_high;
	logic [Q_W-1:0]           q_wdata, q_rdata;
	nrcm_qstat_t              qstat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_dims_q   <= RST_NUM_DIMS;
			extent_q     <= {LANES{RST_EXTENT}};
			direction_q  <= 1'b0;
			elem_bytes_q <= RST_ELEM_BYTES;
			split_q      <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_reg_e'(cfg_index))
				REG_NUM_DIMS:      num_dims_q   <= cfg_data[NDIM_W-1:0];
				REG_EXTENT_0:      extent_q[0]  <= cfg_data[EXT_REG_W-1:0];
				REG_EXTENT_1:      extent_q[1]  <= cfg_data[EXT_REG_W-1:0];
				REG_EXTENT_2:      extent_q[2]  <= cfg_data[EXT_REG_W-1:0];
				REG_EXTENT_3:      extent_q[3]  <= cfg_data[EXT_REG_W-1:0];
				REG_DIRECTION:     direction_q  <= cfg_data[0];
				REG_ELEMENT_BYTES: elem_bytes_q <= cfg_data[SIZE_W-1:0];
				REG_COMPLEX_SPLIT: split_q      <= cfg_data[0];
				default:           num_dims_q   <= num_dims_q;
			endcase
		end
	end

	// Unused dimensions count as extent one; others are clamped to 1..MAX_EXTENT.
	always_comb begin
		for (int d = 0; d < LANES; d++) begin
			if (NDIM_W'(d) >= num_dims_q || extent_q[d] == '0) begin
				ext[d] = EW'(1);
			end else if (32'(extent_q[d]) > MAX_EXTENT) begin
				ext[d] = EW'(MAX_EXTENT);
			end else begin
				ext[d] = EW'(extent_q[d]);
			end
		end
	end

	always_comb begin
		if (elem_bytes_q == '0) begin
			full_bytes = SIZE_W'(1);
		end else if (32'(elem_bytes_q) > MAX_ELEM_BYTES) begin
			full_bytes = SIZE_W'(MAX_ELEM_BYTES);
		end else begin
			full_bytes = elem_bytes_q;
		end
	end

	// The split-complex side, destination or source by direction, uses half size.
	assign half_bytes     = full_bytes >> 1;
	assign ctrl.num_dims  = num_dims_q;
	assign ctrl.dims_ok   = (num_dims_q != '0) && (32'(num_dims_q) <= MAX_DIMS);
	assign ctrl.direction = direction_q;
	assign ctrl.src_bytes = (direction_q && split_q) ? half_bytes : full_bytes;
	assign ctrl.dst_bytes = (!direction_q && split_q) ? half_bytes : full_bytes;

	nrcm_front #(
		.CW       (CW),
		.EW       (EW),
		.MAX_DIMS (MAX_DIMS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.din       (din),
		.clear     (cfg_we),
		.ext       (ext),
		.ctrl      (ctrl),
		.q_full    (qstat.full),
		.push      (push),
		.cnt       (f_cnt),
		.done      (f_done),
		.err       (f_err),
		.data_low  (f_low),
		.data_high (f_high)
	);

	assign q_wdata = {f_cnt, f_done, f_err, f_high, f_low};

	nrcm_queue #(
		.WIDTH (Q_W),
		.DEPTH (Q_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (q_wdata),
		.pop    (pop),
		.rdata  (q_rdata),
		.stat   (qstat)
	);

	assign {b_cnt, b_done, b_err, b_high, b_low} = q_rdata;

	nrcm_back #(
		.CW (CW),
		.EW (EW)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (!qstat.empty),
		.q_cnt   (b_cnt),
		.q_done  (b_done),
		.q_err   (b_err),
		.q_low   (b_low),
		.q_high  (b_high),
		.q_pop   (pop),
		.ext     (ext),
		.ctrl    (ctrl),
		.dout    (dout)
	);

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		dout.valid && dout.dims_error |-> dout.src_index == '0 && dout.dest_index == '0 &&
		dout.src_byte_offset == '0 && dout.dest_byte_offset == '0 && !dout.array_done)
		else $error("error item carries nonzero fields");

	a_push_fill: assert property (@(posedge clk) disable iff (!arst_n)
		din.valid && din.ready |=> !qstat.empty)
		else $error("accepted item missing from queue");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		qstat.full && !pop |=> qstat.full)
		else $error("queue lost an entry without a pop");

endmodule

### test/tb_top.sv
// Self-checking bench for nd_row_col_major_reorder_top: streams elements under many
// array shapes and compares every index, offset and flag against an in-bench predictor.
// Depends on nrcm_pkg and the nrcm_in_if / nrcm_out_if channel interfaces.
module tb_top import nrcm_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int EXT_CAP      = 4096;
	localparam int RANDOM_ELEMS = 1950;
	localparam int CYCLE_LIMIT  = 400000;

	typedef struct packed {
		logic [DATA_W-1:0] lo;
		logic [DATA_W-1:0] hi;
	} elem_t;

	typedef struct packed {
		logic [IDX_W-1:0]  src_index;
		logic [IDX_W-1:0]  dest_index;
		logic [OFS_W-1:0]  src_ofs;
		logic [OFS_W-1:0]  dest_ofs;
		logic [DATA_W-1:0] lo;
		logic [DATA_W-1:0] hi;
		logic              done;
		logic              err;
	} elem_place_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	nrcm_in_if  din_ch ();
	nrcm_out_if dout_ch ();

	nd_row_col_major_reorder_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.din       (din_ch),
		.dout      (dout_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Shadow configuration and position counters of the predictor.
	logic [NDIM_W-1:0]    m_num_dims;
	logic [EXT_REG_W-1:0] m_extent [4];
	logic                 m_direction;
	logic [SIZE_W-1:0]    m_elem_bytes;
	logic                 m_split;
	longint unsigned      m_pos [4];

	elem_t       pending_elems [$];
	elem_place_t expected_places [$];

	bit steady;
	int mismatches;
	int accepted_cnt;
	int checked_cnt;
	int arrays_done;
	int dims_errors;
	int setups;
	int cycles;

	initial clk = 1'b0;
	always #6 clk = ~clk;

	function automatic longint unsigned eff_extent(input int d);
		longint unsigned e;
		if (d >= m_num_dims)
			return 1;
		e = m_extent[d];
		if (e == 0)
			e = 1;
		if (e > EXT_CAP)
			e = EXT_CAP;
		return e;
	endfunction

	function automatic void model_write(input cfg_reg_e r, input logic [CFG_W-1:0] v);
		int d;
		case (r)
			REG_NUM_DIMS:      m_num_dims = v[NDIM_W-1:0];
			REG_EXTENT_0:      m_extent[0] = v;
			REG_EXTENT_1:      m_extent[1] = v;
			REG_EXTENT_2:      m_extent[2] = v;
			REG_EXTENT_3:      m_extent[3] = v;
			REG_DIRECTION:     m_direction = v[0];
			REG_ELEMENT_BYTES: m_elem_bytes = v[SIZE_W-1:0];
			REG_COMPLEX_SPLIT: m_split = v[0];
			default: ;
		endcase
		for (d = 0; d < 4; d++)
			m_pos[d] = 0;
	endfunction

	// Works out where one element lands and steps the counters in source order.
	function automatic elem_place_t locate_element(input logic [DATA_W-1:0] lo,
			input logic [DATA_W-1:0] hi);
		elem_place_t     r;
		longint unsigned e [4];
		longint unsigned c [4];
		longint unsigned row, col, src, dst, full, half, sb, db;
		bit              done;
		int              n, d;
		r = '0;
		if (m_num_dims < 1 || m_num_dims > 4) begin
			r.err = 1'b1;
			return r;
		end
		n = m_num_dims;
		for (d = 0; d < 4; d++) begin
			e[d] = eff_extent(d);
			c[d] = (d < n) ? m_pos[d] : 0;
			if (c[d] >= e[d])
				c[d] = e[d] - 1;
		end
		row = ((c[0] * e[1] + c[1]) * e[2] + c[2]) * e[3] + c[3];
		col = ((c[3] * e[2] + c[2]) * e[1] + c[1]) * e[0] + c[0];
		full = m_elem_bytes;
		if (full == 0)
			full = 1;
		if (full > MAX_ELEM_BYTES)
			full = MAX_ELEM_BYTES;
		half = full / 2;
		if (!m_direction) begin
			src = row;
			dst = col;
			sb  = full;
			db  = m_split ? half : full;
		end else begin
			src = col;
			dst = row;
			sb  = m_split ? half : full;
			db  = full;
		end
		done = 1'b1;
		if (!m_direction) begin
			for (d = n - 1; d >= 0; d--) begin
				if (c[d] + 1 < e[d]) begin
					c[d] = c[d] + 1;
					done = 1'b0;
					break;
				end
				c[d] = 0;
			end
		end else begin
			for (d = 0; d < n; d++) begin
				if (c[d] + 1 < e[d]) begin
					c[d] = c[d] + 1;
					done = 1'b0;
					break;
				end
				c[d] = 0;
			end
		end
		for (d = 0; d < 4; d++)
			m_pos[d] = (d < n) ? c[d] : 0;
		r.src_index  = src[IDX_W-1:0];
		r.dest_index = dst[IDX_W-1:0];
		r.src_ofs    = OFS_W'(src * sb);
		r.dest_ofs   = OFS_W'(dst * db);
		r.lo         = lo;
		r.hi         = hi;
		r.done       = done;
		return r;
	endfunction

	function automatic void check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %h actual %h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	function automatic logic [DATA_W-1:0] rand_word();
		case ($urandom_range(9))
			0:       return '0;
			1:       return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic logic [CFG_W-1:0] pick_extent();
		case ($urandom_range(19))
			0:       return '0;
			1:       return CFG_W'($urandom_range(8191, 4096));
			2:       return CFG_W'($urandom_range(300, 5));
			default: return CFG_W'($urandom_range(4, 1));
		endcase
	endfunction

	function automatic logic [SIZE_W-1:0] pick_size();
		case ($urandom_range(9))
			0:       return '0;
			1:       return SIZE_W'($urandom_range(31, 17));
			default: return SIZE_W'($urandom_range(16, 1));
		endcase
	endfunction

	// Element driver: one item per handshake, with random gaps unless steady.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			din_ch.valid     <= 1'b0;
			din_ch.data_low  <= '0;
			din_ch.data_high <= '0;
		end else begin
			if (din_ch.valid && din_ch.ready) begin
				expected_places.push_back(locate_element(din_ch.data_low, din_ch.data_high));
				accepted_cnt++;
			end
			if (!din_ch.valid || din_ch.ready) begin
				if (pending_elems.size() != 0 && (steady || $urandom_range(99) >= 8)) begin
					din_ch.valid     <= 1'b1;
					din_ch.data_low  <= pending_elems[0].lo;
					din_ch.data_high <= pending_elems[0].hi;
					void'(pending_elems.pop_front());
				end else begin
					din_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor with random back-pressure.
	always @(posedge clk or negedge arst_n) begin
		elem_place_t want;
		if (!arst_n) begin
			dout_ch.ready <= 1'b0;
		end else begin
			if (dout_ch.valid && dout_ch.ready) begin
				checked_cnt++;
				if (expected_places.size() == 0) begin
					$display("%0t: result with no element outstanding, src_index %h",
						$time, dout_ch.src_index);
					mismatches++;
				end else begin
					want = expected_places.pop_front();
					check_field("src_index", 64'(want.src_index), 64'(dout_ch.src_index));
					check_field("dest_index", 64'(want.dest_index),
						64'(dout_ch.dest_index));
					check_field("src_byte_offset", 64'(want.src_ofs),
						64'(dout_ch.src_byte_offset));
					check_field("dest_byte_offset", 64'(want.dest_ofs),
						64'(dout_ch.dest_byte_offset));
					check_field("out_low", want.lo, dout_ch.out_low);
					check_field("out_high", want.hi, dout_ch.out_high);
					check_field("array_done", 64'(want.done), 64'(dout_ch.array_done));
					check_field("dims_error", 64'(want.err), 64'(dout_ch.dims_error));
					if (want.done)
						arrays_done++;
					if (want.err)
						dims_errors++;
				end
			end
			dout_ch.ready <= steady || ($urandom_range(99) >= 8);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d results outstanding.",
				cycles, expected_places.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic set_reg(input cfg_reg_e r, input logic [CFG_W-1:0] v);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= r;
		cfg_data  <= v;
		model_write(r, v);
	endtask

	task automatic end_writes();
		@(posedge clk);
		cfg_we <= 1'b0;
		setups++;
	endtask

	task automatic wait_idle();
		@(negedge clk);
		while (pending_elems.size() != 0 || din_ch.valid || expected_places.size() != 0)
			@(negedge clk);
	endtask

	task automatic push_elems(input int n);
		elem_t el;
		int    i;
		@(negedge clk);
		for (i = 0; i < n; i++) begin
			el.lo = rand_word();
			el.hi = rand_word();
			pending_elems.push_back(el);
		end
		wait_idle();
	endtask

	// Draws a new shape and layout, then returns how many elements to stream.
	// Small shapes get whole arrays and sometimes a partial one so the wrap is exercised.
	task automatic random_setup(output int n);
		logic [CFG_W-1:0] v;
		longint unsigned  prod;
		logic [2:0]       nd;
		int               i, writes;
		if ($urandom_range(19) == 0)
			nd = $urandom_range(1) ? 3'd0 : 3'($urandom_range(7, 5));
		else
			nd = 3'($urandom_range(4, 1));
		writes = 0;
		for (i = 0; i < 8; i++) begin
			if ($urandom_range(3) != 0) begin
				v = CFG_W'($urandom_range(8191));
				case (cfg_reg_e'(i))
					REG_NUM_DIMS:      v[NDIM_W-1:0] = nd;
					REG_EXTENT_0, REG_EXTENT_1, REG_EXTENT_2, REG_EXTENT_3:
						v = pick_extent();
					REG_ELEMENT_BYTES: v[SIZE_W-1:0] = pick_size();
					default: ;
				endcase
				set_reg(cfg_reg_e'(i), v);
				writes++;
			end
		end
		if (writes == 0)
			set_reg(REG_DIRECTION, 13'($urandom_range(8191)));
		end_writes();
		prod = 1;
		for (i = 0; i < 4; i++)
			prod = prod * eff_extent(i);
		if (m_num_dims < 1 || m_num_dims > 4 || prod > 200)
			n = $urandom_range(40, 5);
		else
			n = int'(prod) * $urandom_range(2, 1) + $urandom_range(int'(prod) - 1, 0);
	endtask

	initial begin
		int    n, rand_sent;
		elem_t el;
		arst_n           = 1'b0;
		cfg_we           = 1'b0;
		cfg_index        = '0;
		cfg_data         = '0;
		steady           = 1'b0;
		m_num_dims       = RST_NUM_DIMS;
		m_direction      = 1'b0;
		m_elem_bytes     = RST_ELEM_BYTES;
		m_split          = 1'b0;
		for (n = 0; n < 4; n++) begin
			m_extent[n] = RST_EXTENT;
			m_pos[n]    = 0;
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Reset shape is a single element, so every item completes an array.
		@(negedge clk);
		el.lo = '0;
		el.hi = '0;
		pending_elems.push_back(el);
		el.lo = '1;
		el.hi = '1;
		pending_elems.push_back(el);
		wait_idle();

		// Bad dimension counts give an error result and leave the counters alone.
		set_reg(REG_NUM_DIMS, 13'd0);
		end_writes();
		push_elems(1);
		set_reg(REG_NUM_DIMS, 13'd5);
		end_writes();
		push_elems(1);
		set_reg(REG_NUM_DIMS, 13'h1FFF);
		end_writes();
		push_elems(1);

		// One dimension is the identity; a zero element size counts as one byte.
		set_reg(REG_NUM_DIMS, 13'd1);
		set_reg(REG_EXTENT_0, 13'd3);
		set_reg(REG_DIRECTION, 13'd1);
		set_reg(REG_ELEMENT_BYTES, 13'd0);
		set_reg(REG_COMPLEX_SPLIT, 13'd1);
		end_writes();
		push_elems(4);

		// Zero extent counts as one, oversize extent and element size saturate.
		set_reg(REG_NUM_DIMS, 13'd2);
		set_reg(REG_EXTENT_0, 13'd0);
		set_reg(REG_EXTENT_1, 13'h1FFF);
		set_reg(REG_DIRECTION, 13'd0);
		set_reg(REG_ELEMENT_BYTES, 13'd31);
		end_writes();
		push_elems(3);

		// Full four-dimensional walk, column-major source with a split side.
		set_reg(REG_NUM_DIMS, 13'd4);
		set_reg(REG_EXTENT_0, 13'd2);
		set_reg(REG_EXTENT_1, 13'd1);
		set_reg(REG_EXTENT_2, 13'd2);
		set_reg(REG_EXTENT_3, 13'd2);
		set_reg(REG_DIRECTION, 13'd1);
		set_reg(REG_ELEMENT_BYTES, 13'd7);
		end_writes();
		push_elems(8);

		// A write in the middle of an array restarts it from the first element.
		set_reg(REG_NUM_DIMS, 13'd2);
		set_reg(REG_EXTENT_0, 13'd3);
		set_reg(REG_EXTENT_1, 13'd2);
		set_reg(REG_DIRECTION, 13'd0);
		set_reg(REG_ELEMENT_BYTES, 13'd16);
		set_reg(REG_COMPLEX_SPLIT, 13'd0);
		end_writes();
		push_elems(2);
		set_reg(REG_EXTENT_3, 13'd4096);
		end_writes();
		push_elems(2);

		// One long run with both sides always willing.
		set_reg(REG_NUM_DIMS, 13'd3);
		set_reg(REG_EXTENT_0, 13'd7);
		set_reg(REG_EXTENT_1, 13'd9);
		set_reg(REG_EXTENT_2, 13'd5);
		set_reg(REG_DIRECTION, 13'd1);
		set_reg(REG_COMPLEX_SPLIT, 13'd1);
		end_writes();
		@(negedge clk);
		steady = 1'b1;
		push_elems(630);
		steady = 1'b0;
		rand_sent = 630;

		while (rand_sent < RANDOM_ELEMS) begin
			random_setup(n);
			push_elems(n);
			rand_sent += n;
		end

		repeat (10) @(posedge clk);
		$display("Streamed %0d elements under %0d register setups.", accepted_cnt, setups);
		$display("Checked %0d results: %0d completed arrays, %0d bad-dimension results.",
			checked_cnt, arrays_done, dims_errors);
		if (mismatches == 0 && expected_places.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
